@@ sv/erdcrc_pkg.sv @@
// ----------------------------------------------------------------------------
// erdcrc_pkg
// Shared constants and the byte-wide CRC-32 update for the event record
// decoder.
// ----------------------------------------------------------------------------
package erdcrc_pkg;

    // Record layout
    localparam int RECORD_BYTES = 72;
    localparam int POS_W        = $clog2(RECORD_BYTES);
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 64;
    localparam int HALF_W       = 32;
    localparam int SHORT_W      = 16;
    localparam int CRC_W        = 32;
    localparam int WIDE_N       = 7;
    localparam int WIDE_IDX_W   = $clog2(WIDE_N);
    localparam int LANE_W       = $clog2(WORD_W / BYTE_W);
    localparam int SUM_LANE_W   = $clog2(CRC_W / BYTE_W);

    // Byte positions of the field groups
    localparam int NARROW_FIRST = 32;
    localparam int NARROW_LAST  = 40;
    localparam int CRC_FIRST    = 8;
    localparam int CRC_LAST     = 64;
    localparam int SUM_FIRST    = 64;
    localparam int SUM_LAST     = 68;
    localparam int TAIL_FIRST   = 4;

    // CRC-32, reflected form
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // Advance the reflected CRC by one byte, one bit per step
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W - BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

@@ sv/erdcrc_if.sv @@
// ----------------------------------------------------------------------------
// erdcrc channel interfaces
// Byte stream channel and decoded record channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface erdcrc_byte_if;
    logic                           valid;
    logic                           ready;
    logic [erdcrc_pkg::BYTE_W-1:0]  data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface erdcrc_rec_if;
    logic                           valid;
    logic                           ready;
    logic                           crc_ok;
    logic [erdcrc_pkg::WORD_W-1:0]  record_sequence;
    logic [erdcrc_pkg::WORD_W-1:0]  event_time;
    logic [erdcrc_pkg::WORD_W-1:0]  process_id_token;
    logic [erdcrc_pkg::WORD_W-1:0]  session_id_token;
    logic [erdcrc_pkg::SHORT_W-1:0] event_kind;
    logic [erdcrc_pkg::SHORT_W-1:0] event_flag_bits;
    logic [erdcrc_pkg::HALF_W-1:0]  link_generation;
    logic [erdcrc_pkg::WORD_W-1:0]  value_first;
    logic [erdcrc_pkg::WORD_W-1:0]  value_second;
    logic [erdcrc_pkg::WORD_W-1:0]  value_third;

    modport source (
        output valid, input ready,
        output crc_ok, output record_sequence, output event_time,
        output process_id_token, output session_id_token, output event_kind,
        output event_flag_bits, output link_generation, output value_first,
        output value_second, output value_third
    );
    modport sink (
        input valid, output ready,
        input crc_ok, input record_sequence, input event_time,
        input process_id_token, input session_id_token, input event_kind,
        input event_flag_bits, input link_generation, input value_first,
        input value_second, input value_third
    );
endinterface

@@ sv/event_record_decoder_crc32.sv @@
// ----------------------------------------------------------------------------
// event_record_decoder_crc32
// Splits a byte stream of 72-byte little-endian event records into fields
// and checks each record against its stored CRC-32.
//
// Usage:
//   stream carries one byte per transfer; records follow each other with no
//   gap, the first byte after reset being byte 0 of a record.
//   record carries one decoded record per 72 input bytes. When the stored
//   checksum (bytes 64..67) matches the CRC-32 over bytes 8..63, crc_ok is
//   set and the ten fields are valid; otherwise crc_ok is clear and every
//   field is zero. Bytes 68..71 are ignored.
//   Throughput: one byte per cycle unless byte 71 is held off. The CRC
//   takes a full byte each cycle through an unrolled eight-step update.
//   Latency: the result is valid in the cycle after the transfer of byte 71.
//   Stall: the result sits in an output register; bytes keep flowing while it
//   waits, and only byte 71 of the next record is held off until it is taken.
//   Reset: the byte position returns to 0, the CRC to all ones, and no
//   result is pending.
// ----------------------------------------------------------------------------
module event_record_decoder_crc32 (
    input  logic           clk,
    input  logic           rst_n,
    erdcrc_byte_if.sink    stream,
    erdcrc_rec_if.source   record
);
    import erdcrc_pkg::*;

    // Control state
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [CRC_W-1:0]      crc_reg, crc_next;
    logic                  out_valid_reg, out_valid_next;

    // Captured fields
    logic [WORD_W-1:0]     wide_reg [WIDE_N];
    logic [WORD_W-1:0]     narrow_reg;
    logic [CRC_W-1:0]      sum_reg;

    // Result register
    logic                  ok_reg;
    logic [WORD_W-1:0]     res_wide_reg [WIDE_N];
    logic [WORD_W-1:0]     res_narrow_reg;

    // Decode
    logic [POS_W-1:0]      pos_cur;
    logic                  is_last;
    logic                  in_xfer;
    logic                  out_xfer;
    logic                  wide_we;
    logic                  narrow_we;
    logic                  sum_we;
    logic                  crc_en;
    logic [WIDE_IDX_W-1:0] wide_idx;
    logic [LANE_W-1:0]     lane;
    logic [SUM_LANE_W-1:0] sum_lane;
    logic                  crc_match;

    // Work out where the current byte lands
    always_comb
    begin
        pos_cur   = (pos_reg >= POS_W'(RECORD_BYTES)) ? '0 : pos_reg;
        is_last   = (pos_cur == POS_W'(RECORD_BYTES - 1));
        lane      = pos_cur[LANE_W-1:0];
        sum_lane  = pos_cur[SUM_LANE_W-1:0];
        wide_we   = (pos_cur < POS_W'(NARROW_FIRST))
                    || ((pos_cur >= POS_W'(NARROW_LAST)) && (pos_cur < POS_W'(CRC_LAST)));
        narrow_we = (pos_cur >= POS_W'(NARROW_FIRST)) && (pos_cur < POS_W'(NARROW_LAST));
        sum_we    = (pos_cur >= POS_W'(SUM_FIRST)) && (pos_cur < POS_W'(SUM_LAST));
        crc_en    = (pos_cur >= POS_W'(CRC_FIRST)) && (pos_cur < POS_W'(CRC_LAST));
        if (pos_cur < POS_W'(NARROW_FIRST))
        begin
            wide_idx = WIDE_IDX_W'(pos_cur >> LANE_W);
        end
        else
        begin
            wide_idx = WIDE_IDX_W'(((pos_cur - POS_W'(NARROW_LAST)) >> LANE_W)
                                   + POS_W'(TAIL_FIRST));
        end
        crc_match = (sum_reg == (crc_reg ^ CRC_ONES));
    end

    // Hold off only the closing byte while a result is still waiting
    assign stream.ready = !(is_last && out_valid_reg && !record.ready);
    assign in_xfer      = stream.valid && stream.ready;
    assign out_xfer     = out_valid_reg && record.ready;

    // Advance position, CRC and result flag
    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            if (is_last)
            begin
                pos_next       = '0;
                crc_next       = CRC_ONES;
                out_valid_next = 1'b1;
            end
            else
            begin
                pos_next = pos_cur + POS_W'(1);
                if (crc_en)
                begin
                    crc_next = crc32_byte(crc_reg, stream.data_byte);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            crc_reg       <= CRC_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture each byte into its field lane
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (wide_we)
            begin
                wide_reg[wide_idx][{lane, 3'b000} +: BYTE_W] <= stream.data_byte;
            end
            if (narrow_we)
            begin
                narrow_reg[{lane, 3'b000} +: BYTE_W] <= stream.data_byte;
            end
            if (sum_we)
            begin
                sum_reg[{sum_lane, 3'b000} +: BYTE_W] <= stream.data_byte;
            end
        end
    end

    // Load the result on the closing byte; zero the fields on a mismatch
    always_ff @(posedge clk)
    begin
        if (in_xfer && is_last)
        begin
            ok_reg         <= crc_match;
            res_narrow_reg <= crc_match ? narrow_reg : '0;
            for (int i = 0; i < WIDE_N; i++)
            begin
                res_wide_reg[i] <= crc_match ? wide_reg[i] : '0;
            end
        end
    end

    // Drive the result channel
    assign record.valid            = out_valid_reg;
    assign record.crc_ok           = ok_reg;
    assign record.record_sequence  = res_wide_reg[0];
    assign record.event_time       = res_wide_reg[1];
    assign record.process_id_token = res_wide_reg[2];
    assign record.session_id_token = res_wide_reg[3];
    assign record.event_kind       = res_narrow_reg[SHORT_W-1:0];
    assign record.event_flag_bits  = res_narrow_reg[2*SHORT_W-1:SHORT_W];
    assign record.link_generation  = res_narrow_reg[WORD_W-1:HALF_W];
    assign record.value_first      = res_wide_reg[4];
    assign record.value_second     = res_wide_reg[5];
    assign record.value_third      = res_wide_reg[6];

endmodule
